[rtl/core/damage_rect_list_merge_assert.svh]
// Assertion macros for the damage rectangle list block.
`ifndef DAMAGE_RECT_LIST_MERGE_ASSERT_SVH
`define DAMAGE_RECT_LIST_MERGE_ASSERT_SVH
// Checks that a condition implies a consequence on the same edge.
`define DRLM_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence on the next edge.
`define DRLM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/core/drlm_pkg.sv]
// ---------------------------------------------------------------------------
// drlm_pkg
// Shared types and constants of the damage rectangle list block.
// ---------------------------------------------------------------------------
`default_nettype none
package drlm_pkg;
   localparam int MaxEntries = 16;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int CoordW = 13;
   localparam int InW = 16;

   localparam logic [1:0] CSR_SCREEN_WIDTH = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TASKBAR_HEIGHT = 2'd2;

   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // An entry kept as corners: x1, y1, x2, y2.
   typedef struct packed {
      logic [CoordW-1:0] x1;
      logic [CoordW-1:0] y1;
      logic [CoordW-1:0] x2;
      logic [CoordW-1:0] y2;
   } box_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clip;         // register the clipped rectangle
      logic rd;           // read entry at rd_idx
      logic [IdxW-1:0] rd_idx;
      logic merge_acc;    // grow accumulator with read entry
      logic load_acc;     // accumulator takes read entry, grows with rect
      logic wr_acc;       // write accumulator at wr_idx
      logic wr_rect;      // write rect at wr_idx
      logic wr_rd;        // write read entry at wr_idx
      logic [IdxW-1:0] wr_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drop;          // clipped rectangle is empty
      logic touch_rect;    // read entry touches rect
      logic touch_acc;     // read entry touches accumulator
   } sts_type;
endpackage
`default_nettype wire

[rtl/core/damage_rect_list_merge.sv]
// ---------------------------------------------------------------------------
// damage_rect_list_merge
// Bounded list of screen damage rectangles with merge on add and flush.
// ---------------------------------------------------------------------------
// Channel  Ports                      Handshake
// request  req_*, start, busy         accepted when start and not busy
// response rsp_*, rsp_strobe          one strobe per word, no stall
// config   csr_*                      csr_valid and csr_ready
//
// An add runs the drop check, scans for the first entry that touches the
// rectangle, then sweeps so the merged entry absorbs touching entries, each
// freed slot taking the last entry, and ends with the response word. A
// flush reads and emits each entry in order. A full list collapses into
// slot zero after the scan. Reset empties the list and loads the default
// screen size. Responses cannot be stalled.
`default_nettype none
module damage_rect_list_merge (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic req_type,
   input  wire logic [15:0] req_in_x,
   input  wire logic [15:0] req_in_y,
   input  wire logic [15:0] req_in_w,
   input  wire logic [15:0] req_in_h,
   output logic rsp_strobe,
   output logic [12:0] rsp_out_x,
   output logic [12:0] rsp_out_y,
   output logic [12:0] rsp_out_w,
   output logic [12:0] rsp_out_h,
   output logic rsp_rect_valid,
   output logic [4:0] rsp_entry_count,
   output logic rsp_last,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [12:0] csr_data
);
   import drlm_pkg::*;

   logic [12:0] sw_ff, sh_ff, tb_ff;
   cmd_type cmd;
   sts_type sts;
   box_type rd_box;
   logic flush;
   logic [CntW-1:0] cnt;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= 13'd1024;
         sh_ff <= 13'd768;
         tb_ff <= 13'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: sw_ff <= csr_data;
            CSR_SCREEN_HEIGHT: sh_ff <= csr_data;
            CSR_TASKBAR_HEIGHT: tb_ff <= csr_data;
            default: ;
         endcase
      end
   end

   drlm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_strobe(rsp_strobe),
      .rsp_flush(flush), .rsp_count(cnt), .rsp_last(rsp_last)
   );

   drlm_datapath u_dp (
      .clock(clock), .screen_width(sw_ff), .screen_height(sh_ff),
      .taskbar_height(tb_ff), .in_x(req_in_x), .in_y(req_in_y),
      .in_w(req_in_w), .in_h(req_in_h), .cmd(cmd), .sts(sts), .rd_box(rd_box)
   );

   // Output word: entries are stored as corners.
   assign rsp_out_x = flush ? rd_box.x1 : '0;
   assign rsp_out_y = flush ? rd_box.y1 : '0;
   assign rsp_out_w = flush ? (rd_box.x2 - rd_box.x1) : '0;
   assign rsp_out_h = flush ? (rd_box.y2 - rd_box.y1) : '0;
   assign rsp_rect_valid = flush;
   assign rsp_entry_count = 5'(cnt);
endmodule
`default_nettype wire

[rtl/core/drlm_datapath.sv]
// ---------------------------------------------------------------------------
// drlm_datapath
// Clipping, rectangle memory, touch tests and the merge accumulator.
// ---------------------------------------------------------------------------
`default_nettype none
module drlm_datapath (
   input  wire logic clock,
   input  wire logic [12:0] screen_width,
   input  wire logic [12:0] screen_height,
   input  wire logic [12:0] taskbar_height,
   input  wire logic [15:0] in_x,
   input  wire logic [15:0] in_y,
   input  wire logic [15:0] in_w,
   input  wire logic [15:0] in_h,
   input  wire drlm_pkg::cmd_type cmd,
   output drlm_pkg::sts_type sts,
   output drlm_pkg::box_type rd_box
);
   import drlm_pkg::*;

   box_type mem [MaxEntries];
   box_type rd_ff, rect_ff, acc_ff, acc_in, wdata;
   logic drop_ff;
   logic signed [17:0] xa, xb, ya, yb, sw, sh, lim;
   logic signed [17:0] x1, x2, y1, y2;
   logic drop_in;

   // Clamp the edges to the screen and the taskbar line.
   always_comb begin
      sw = {5'd0, screen_width};
      sh = {5'd0, screen_height};
      lim = sh - {5'd0, taskbar_height};
      xa = {{2{in_x[15]}}, in_x};
      ya = {{2{in_y[15]}}, in_y};
      xb = xa + {{2{in_w[15]}}, in_w};
      yb = ya + {{2{in_h[15]}}, in_h};
      x1 = (xa < 0) ? 18'sd0 : (xa > sw) ? sw : xa;
      x2 = (xb < 0) ? 18'sd0 : (xb > sw) ? sw : xb;
      y1 = (ya < 0) ? 18'sd0 : (ya > sh) ? sh : ya;
      y2 = (yb < 0) ? 18'sd0 : (yb > sh) ? sh : yb;
      drop_in = in_w[15] || (in_w == '0) || in_h[15] || (in_h == '0) ||
                (x1 >= x2) || (y1 >= y2) || (y1 >= lim);
      if (y2 > lim) begin
         y2 = lim;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         drop_ff <= drop_in;
         rect_ff <= '{x1[12:0], y1[12:0], x2[12:0], y2[12:0]};
      end
   end

   function automatic logic touch(box_type a, box_type b);
      return (a.x1 <= b.x2) && (a.x2 >= b.x1) && (a.y1 <= b.y2) && (a.y2 >= b.y1);
   endfunction

   function automatic box_type grow(box_type a, box_type b);
      box_type r;
      r.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
      r.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
      r.x2 = (a.x2 > b.x2) ? a.x2 : b.x2;
      r.y2 = (a.y2 > b.y2) ? a.y2 : b.y2;
      return r;
   endfunction

   // Accumulator update.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_acc) begin
         acc_in = grow(rd_ff, rect_ff);
      end else if (cmd.merge_acc) begin
         acc_in = grow(acc_ff, rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Entry memory, one write and one registered read a cycle.
   always_comb begin
      wdata = rd_ff;
      if (cmd.wr_acc) begin
         wdata = acc_in;
      end else if (cmd.wr_rect) begin
         wdata = rect_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_acc || cmd.wr_rect || cmd.wr_rd) begin
         mem[cmd.wr_idx] <= wdata;
      end
      if (cmd.rd) begin
         rd_ff <= mem[cmd.rd_idx];
      end
   end

   assign sts.drop = drop_ff;
   assign sts.touch_rect = touch(rd_ff, rect_ff);
   assign sts.touch_acc = touch(rd_ff, acc_ff);
   assign rd_box = rd_ff;
endmodule
`default_nettype wire

[rtl/core/drlm_ctrl.sv]
// ---------------------------------------------------------------------------
// drlm_ctrl
// Sequencer for add scans, merge sweeps, collapse and flush.
// ---------------------------------------------------------------------------
`default_nettype none
module drlm_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic req_type,
   input  wire drlm_pkg::sts_type sts,
   output drlm_pkg::cmd_type cmd,
   output logic busy,
   output logic rsp_strobe,
   output logic rsp_flush,
   output logic [drlm_pkg::CntW-1:0] rsp_count,
   output logic rsp_last
);
   import drlm_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_SCAN_RD = 4'd2;
   localparam logic [3:0] S_SCAN_TST = 4'd3;
   localparam logic [3:0] S_SW_RD = 4'd4;
   localparam logic [3:0] S_SW_TST = 4'd5;
   localparam logic [3:0] S_MOVE_RD = 4'd6;
   localparam logic [3:0] S_MOVE_WR = 4'd7;
   localparam logic [3:0] S_COL_RD = 4'd8;
   localparam logic [3:0] S_COL_TST = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;
   localparam logic [3:0] S_FL_RD = 4'd11;
   localparam logic [3:0] S_FL_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CntW-1:0] nm1;

   assign nm1 = n_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      cmd = '0;
      busy = (state_ff != S_IDLE);
      rsp_strobe = 1'b0;
      rsp_flush = 1'b0;
      rsp_count = n_ff;
      rsp_last = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in = '0;
               cmd.clip = 1'b1;
               state_in = (req_type == REQ_FLUSH) ? S_FL_RD : S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.drop) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         // Look for the first entry that touches the rectangle.
         S_SCAN_RD: begin
            if (i_ff == n_ff) begin
               if (n_ff < CntW'(MaxEntries)) begin
                  cmd.wr_rect = 1'b1;
                  cmd.wr_idx = i_ff[IdxW-1:0];
                  n_in = n_ff + 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.rd = 1'b1;
                  cmd.rd_idx = '0;
                  j_in = CntW'(1);
                  state_in = S_COL_RD;
               end
            end else begin
               cmd.rd = 1'b1;
               cmd.rd_idx = i_ff[IdxW-1:0];
               state_in = S_SCAN_TST;
            end
         end
         S_SCAN_TST: begin
            if (sts.touch_rect) begin
               cmd.load_acc = 1'b1;
               cmd.wr_acc = 1'b1;
               cmd.wr_idx = i_ff[IdxW-1:0];
               j_in = '0;
               state_in = S_SW_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         // Sweep: the merged entry absorbs touching entries.
         S_SW_RD: begin
            if (j_ff == n_ff) begin
               state_in = S_DONE;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               cmd.rd = 1'b1;
               cmd.rd_idx = j_ff[IdxW-1:0];
               state_in = S_SW_TST;
            end
         end
         S_SW_TST: begin
            if (sts.touch_acc) begin
               cmd.merge_acc = 1'b1;
               cmd.wr_acc = 1'b1;
               cmd.wr_idx = i_ff[IdxW-1:0];
               state_in = S_MOVE_RD;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_MOVE_RD: begin
            cmd.rd = 1'b1;
            cmd.rd_idx = nm1[IdxW-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.wr_rd = 1'b1;
            cmd.wr_idx = j_ff[IdxW-1:0];
            if (i_ff == nm1) begin
               i_in = j_ff;
            end
            n_in = nm1;
            state_in = S_SW_RD;
         end
         // Full list: fold everything into slot zero.
         S_COL_RD: begin
            if (j_ff == CntW'(1)) begin
               cmd.load_acc = 1'b1;
            end else begin
               cmd.merge_acc = 1'b1;
            end
            if (j_ff == n_ff) begin
               cmd.wr_acc = 1'b1;
               cmd.wr_idx = '0;
               n_in = CntW'(1);
               state_in = S_DONE;
            end else begin
               cmd.rd = 1'b1;
               cmd.rd_idx = j_ff[IdxW-1:0];
               state_in = S_COL_TST;
            end
         end
         S_COL_TST: begin
            cmd.merge_acc = 1'b1;
            j_in = j_ff + 1'b1;
            if (j_ff + 1'b1 == n_ff) begin
               cmd.wr_acc = 1'b1;
               cmd.wr_idx = '0;
               n_in = CntW'(1);
               state_in = S_DONE;
            end else begin
               cmd.rd = 1'b1;
               cmd.rd_idx = IdxW'(j_ff + 1'b1);
            end
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in = S_IDLE;
         end
         // Flush: read and emit each entry in order.
         S_FL_RD: begin
            if (n_ff == '0) begin
               rsp_strobe = 1'b1;
               rsp_count = '0;
               state_in = S_IDLE;
            end else begin
               cmd.rd = 1'b1;
               cmd.rd_idx = i_ff[IdxW-1:0];
               state_in = S_FL_OUT;
            end
         end
         S_FL_OUT: begin
            rsp_strobe = 1'b1;
            rsp_flush = 1'b1;
            rsp_count = '0;
            rsp_last = (i_ff + 1'b1 == n_ff);
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) begin
               n_in = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_FL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end
endmodule
`default_nettype wire

[rtl/core/drlm_checker.sv]
// ---------------------------------------------------------------------------
// drlm_checker
// Port-level checks of the damage rectangle list block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "damage_rect_list_merge_assert.svh"
module drlm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_rect_valid,
   input wire logic [4:0] rsp_entry_count,
   input wire logic rsp_last
);
   // An accepted request makes the block busy.
   `DRLM_ASSERT_NEXT(a_busy, clock, reset, start && !busy, busy)
   // A word carrying an entry reports a zero count.
   `DRLM_ASSERT_IMP(a_cnt, clock, reset, rsp_strobe && rsp_rect_valid,
      rsp_entry_count == 5'd0)
   // Add responses are always the final word.
   `DRLM_ASSERT_IMP(a_add_last, clock, reset, rsp_strobe && !rsp_rect_valid, rsp_last)
   // A last word leaves the block idle.
   `DRLM_ASSERT_NEXT(a_idle, clock, reset, rsp_strobe && rsp_last, !busy)
endmodule

bind damage_rect_list_merge drlm_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_rect_valid(rsp_rect_valid),
   .rsp_entry_count(rsp_entry_count), .rsp_last(rsp_last)
);
`default_nettype wire

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Damage rectangle list testbench
// Drives add and flush commands into the damage list block under several
// screen settings and checks every response word against a behavioral
// model of the list kept in this file.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import drlm_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int ListDepth = 16;

   typedef struct {
      logic kind;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
   } cmd_word_type;

   typedef struct {
      logic [12:0] x;
      logic [12:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic rect_valid;
      logic [4:0] count;
      logic last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_type = REQ_ADD;
   logic [15:0] req_in_x = '0;
   logic [15:0] req_in_y = '0;
   logic [15:0] req_in_w = '0;
   logic [15:0] req_in_h = '0;
   logic csr_valid = 1'b0;
   logic [1:0] csr_index = CSR_SCREEN_WIDTH;
   logic [12:0] csr_data = '0;
   logic busy;
   logic rsp_strobe;
   logic [12:0] rsp_out_x;
   logic [12:0] rsp_out_y;
   logic [12:0] rsp_out_w;
   logic [12:0] rsp_out_h;
   logic rsp_rect_valid;
   logic [4:0] rsp_entry_count;
   logic rsp_last;
   logic csr_ready;

   // Model state of the damage list and its clip settings.
   int ent_x[ListDepth];
   int ent_y[ListDepth];
   int ent_w[ListDepth];
   int ent_h[ListDepth];
   int list_len;
   int scr_w;
   int scr_h;
   int bar_h;

   cmd_word_type cmd_queue[$];
   rsp_word_type rsp_queue[$];
   cmd_word_type cur_cmd;
   bit no_gaps;
   int error_count;
   int cycle_count;
   int add_count;
   int flush_count;
   int word_count;
   int collapse_count;
   int max_len;

   damage_rect_list_merge DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Model of the list: edges inclusive touch test.
   function automatic bit boxes_touch(int ax, int ay, int aw, int ah,
                                      int bx, int by, int bw, int bh);
      return ax <= bx + bw && ax + aw >= bx && ay <= by + bh && ay + ah >= by;
   endfunction

   // Grows entry d to the bounding box of itself and the given box.
   task automatic grow_entry(int d, int sx, int sy, int sw, int sh);
      int x1, y1, x2, y2;
      x1 = ent_x[d] < sx ? ent_x[d] : sx;
      y1 = ent_y[d] < sy ? ent_y[d] : sy;
      x2 = ent_x[d] + ent_w[d] > sx + sw ? ent_x[d] + ent_w[d] : sx + sw;
      y2 = ent_y[d] + ent_h[d] > sy + sh ? ent_y[d] + ent_h[d] : sy + sh;
      ent_x[d] = x1;
      ent_y[d] = y1;
      ent_w[d] = x2 - x1;
      ent_h[d] = y2 - y1;
   endtask

   function automatic int clamp_int(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Clips and merges one rectangle into the model list.
   task automatic merge_rect(int x, int y, int w, int h);
      int x1, x2, y1, y2, lim, n, i, j;
      x1 = clamp_int(x, 0, scr_w);
      x2 = clamp_int(x + w, 0, scr_w);
      y1 = clamp_int(y, 0, scr_h);
      y2 = clamp_int(y + h, 0, scr_h);
      lim = scr_h - bar_h;
      n = list_len;
      if (w <= 0 || h <= 0 || x1 >= x2 || y1 >= y2 || y1 >= lim) return;
      if (y2 > lim) y2 = lim;
      for (i = 0; i < n; i++) begin
         if (boxes_touch(ent_x[i], ent_y[i], ent_w[i], ent_h[i],
                         x1, y1, x2 - x1, y2 - y1)) begin
            grow_entry(i, x1, y1, x2 - x1, y2 - y1);
            j = 0;
            while (j < n) begin
               if (j == i || !boxes_touch(ent_x[i], ent_y[i], ent_w[i], ent_h[i],
                                          ent_x[j], ent_y[j], ent_w[j], ent_h[j]))
               begin
                  j++;
               end else begin
                  grow_entry(i, ent_x[j], ent_y[j], ent_w[j], ent_h[j]);
                  ent_x[j] = ent_x[n-1];
                  ent_y[j] = ent_y[n-1];
                  ent_w[j] = ent_w[n-1];
                  ent_h[j] = ent_h[n-1];
                  // The merged entry itself was moved into slot j.
                  if (i == n - 1) i = j;
                  n--;
               end
            end
            list_len = n;
            return;
         end
      end
      if (n < ListDepth) begin
         ent_x[n] = x1;
         ent_y[n] = y1;
         ent_w[n] = x2 - x1;
         ent_h[n] = y2 - y1;
         list_len = n + 1;
         return;
      end
      // Full list collapses into one bounding box.
      for (j = 1; j < n; j++) grow_entry(0, ent_x[j], ent_y[j], ent_w[j], ent_h[j]);
      grow_entry(0, x1, y1, x2 - x1, y2 - y1);
      list_len = 1;
      collapse_count++;
   endtask

   // Works out the response words of one accepted command word.
   task automatic predict_words(cmd_word_type c);
      rsp_word_type r;
      r = '{default: '0};
      if (c.kind == REQ_ADD) begin
         merge_rect(int'($signed(c.x)), int'($signed(c.y)),
                    int'($signed(c.w)), int'($signed(c.h)));
         if (list_len > max_len) max_len = list_len;
         r.count = 5'(list_len);
         r.last = 1'b1;
         rsp_queue.push_back(r);
         add_count++;
      end else begin
         flush_count++;
         if (list_len == 0) begin
            r.last = 1'b1;
            rsp_queue.push_back(r);
         end
         for (int k = 0; k < list_len; k++) begin
            r.x = 13'(ent_x[k]);
            r.y = 13'(ent_y[k]);
            r.w = 13'(ent_w[k]);
            r.h = 13'(ent_h[k]);
            r.rect_valid = 1'b1;
            r.last = (k == list_len - 1);
            rsp_queue.push_back(r);
         end
         list_len = 0;
      end
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Driver: issues queued command words on the start/busy handshake.
   always @(posedge clock) begin
      logic taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) predict_words(cur_cmd);
         if ((!start || taken) && cmd_queue.size() > 0 &&
             (no_gaps || $urandom_range(0, 99) >= 36)) begin
            cur_cmd = cmd_queue.pop_front();
            req_type <= cur_cmd.kind;
            req_in_x <= cur_cmd.x;
            req_in_y <= cur_cmd.y;
            req_in_w <= cur_cmd.w;
            req_in_h <= cur_cmd.h;
            start <= 1'b1;
         end else if (taken) begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compares each response word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_strobe) begin
         word_count++;
         if (rsp_queue.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            e = rsp_queue.pop_front();
            if (rsp_out_x !== e.x)
               report_mismatch($sformatf("out_x %0d, expected %0d", rsp_out_x, e.x));
            if (rsp_out_y !== e.y)
               report_mismatch($sformatf("out_y %0d, expected %0d", rsp_out_y, e.y));
            if (rsp_out_w !== e.w)
               report_mismatch($sformatf("out_w %0d, expected %0d", rsp_out_w, e.w));
            if (rsp_out_h !== e.h)
               report_mismatch($sformatf("out_h %0d, expected %0d", rsp_out_h, e.h));
            if (rsp_rect_valid !== e.rect_valid)
               report_mismatch($sformatf("rect_valid %0b, expected %0b",
                                         rsp_rect_valid, e.rect_valid));
            if (rsp_entry_count !== e.count)
               report_mismatch($sformatf("entry_count %0d, expected %0d",
                                         rsp_entry_count, e.count));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last, e.last));
         end
      end
   end

   // Watchdog on the run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_cmd(logic kind, int x, int y, int w, int h);
      cmd_word_type c;
      c.kind = kind;
      c.x = 16'(x);
      c.y = 16'(y);
      c.w = 16'(w);
      c.h = 16'(h);
      cmd_queue.push_back(c);
   endtask

   // Waits until every command is taken and every word has come back.
   task automatic wait_drained();
      while (cmd_queue.size() > 0 || start || busy || rsp_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // One register write, with csr_valid dropped again before the task returns.
   task automatic write_csr(logic [1:0] idx, int value);
      csr_index <= idx;
      csr_data <= 13'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SCREEN_WIDTH: scr_w = value;
         CSR_SCREEN_HEIGHT: scr_h = value;
         default: bar_h = value;
      endcase
      @(posedge clock);
   endtask

   task automatic set_screen(int w, int h, int bar);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      write_csr(CSR_TASKBAR_HEIGHT, bar);
   endtask

   // Random commands: mostly small boxes near the screen, some raw noise and flushes.
   task automatic queue_random(int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 9) begin
            queue_cmd(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 24) begin
            queue_cmd(REQ_ADD, $urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_cmd(REQ_ADD, $urandom_range(0, scr_w + 8) - 8,
                      $urandom_range(0, scr_h + 8) - 8,
                      $urandom_range(0, scr_w / 6 + 2), $urandom_range(0, scr_h / 6 + 2));
         end
      end
   endtask

   initial begin
      list_len = 0;
      scr_w = 1024;
      scr_h = 768;
      bar_h = 0;
      no_gaps = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: clipping extremes, drops, flush of an empty list.
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      queue_cmd(REQ_ADD, -32768, -32768, 32767, 32767);
      queue_cmd(REQ_ADD, 32767, 32767, 32767, 32767);
      queue_cmd(REQ_ADD, 5, 5, -32768, 10);
      queue_cmd(REQ_ADD, 5, 5, 10, 0);
      queue_cmd(REQ_ADD, 2000, 10, 10, 10);
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      // Merged entry in the last slot gets moved by compaction.
      queue_cmd(REQ_ADD, 0, 5, 16, 3);
      queue_cmd(REQ_ADD, 100, 100, 10, 10);
      queue_cmd(REQ_ADD, 20, 0, 10, 10);
      queue_cmd(REQ_ADD, 15, 10, 6, 5);
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      // Fill the list with disjoint boxes, then overflow it.
      for (int k = 0; k < 17; k++) queue_cmd(REQ_ADD, 40 * k, 20 * k, 5, 5);
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      wait_drained();

      // Taskbar cut: a top below the limit drops, a bottom gets cut back.
      set_screen(4096, 4096, 100);
      queue_cmd(REQ_ADD, 10, 3996, 10, 10);
      queue_cmd(REQ_ADD, 4000, 3990, 500, 500);
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      queue_random(40);
      wait_drained();

      // Taskbar taller than the screen drops everything.
      set_screen(300, 200, 4096);
      queue_cmd(REQ_ADD, 0, 0, 50, 50);
      queue_random(15);
      wait_drained();

      set_screen(1, 1, 0);
      queue_random(25);
      wait_drained();

      set_screen(200, 150, 40);
      queue_random(40);
      wait_drained();

      // A stretch with no idling on the sender side.
      no_gaps = 1'b1;
      set_screen(1024, 768, 0);
      queue_random(60);
      wait_drained();
      no_gaps = 1'b0;

      set_screen(640, 480, 48);
      queue_random(55);
      queue_cmd(REQ_FLUSH, 0, 0, 0, 0);
      wait_drained();
      repeat (200) @(posedge clock);

      $display("Covered %0d adds and %0d flushes over seven screen settings.",
               add_count, flush_count);
      $display("Checked %0d response words; longest list %0d, %0d full-list collapses.",
               word_count, max_len, collapse_count);
      if (error_count == 0 && rsp_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
